// ===== design/ptt_pkg.sv =====
// shared types and constants for the periodic timer table
`timescale 1ns / 1ps
package ptt_pkg;
  localparam int unsigned NumTimersDefault = 16;
  localparam int unsigned OpW = 3;
  localparam int unsigned KeyW = 16;
  localparam int unsigned PerW = 32;
  localparam int unsigned TimeW = 48;
  localparam int unsigned StatW = 2;

  typedef enum logic [2:0] {
    OP_SCAN = 3'd0, OP_SET = 3'd1, OP_RESTART = 3'd2, OP_NOTIFY = 3'd3,
    OP_KILL = 3'd4, OP_KILL_ALL = 3'd5, OP_CLEAR = 3'd6, OP_NONE = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_KEY = 2'd2, ST_RSVD = 2'd3
  } status_e;

  // one request as queued between front and back
  typedef struct packed {
    op_e              op;
    logic [KeyW-1:0]  key;
    logic [PerW-1:0]  period;
    logic [TimeW-1:0] now;
  } req_t;
endpackage

// ===== design/ptt_front.sv =====
// front end: request intake and two-entry queue
`timescale 1ns / 1ps
module ptt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ptt_pkg::req_t  req_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output ptt_pkg::req_t  q_req_o
);
  ptt_pkg::req_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= req_i;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== design/ptt_back.sv =====
// back end: table storage and sequencer for requests and scans
`timescale 1ns / 1ps
module ptt_back #(
  parameter int unsigned NumTimers = ptt_pkg::NumTimersDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_ready_o,
  input  ptt_pkg::req_t              q_req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       fired_o,
  output logic [ptt_pkg::KeyW-1:0]   fired_key_o,
  output logic [ptt_pkg::StatW-1:0]  status_o,
  output logic                       last_o
);
  localparam int unsigned IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1;

  typedef enum logic [2:0] {S_IDLE, S_PICK, S_FIRE, S_PURGE, S_OUT} state_e;

  state_e state_q;
  ptt_pkg::req_t req_q;
  logic [NumTimers-1:0] valid_q, doomed_q;
  logic [ptt_pkg::KeyW-1:0]  key_q    [NumTimers];
  logic [ptt_pkg::PerW-1:0]  period_q [NumTimers];
  logic [ptt_pkg::TimeW-1:0] stamp_q  [NumTimers];
  logic [IdxW-1:0] idx_q, pick_q;
  logic have_pick_q, have_prev_q, any_q, pend_q;
  logic [ptt_pkg::KeyW-1:0] prev_q;
  logic [IdxW-1:0] fkey_idx_q;
  logic out_valid_q, fired_q, last_q;
  logic [ptt_pkg::KeyW-1:0] fkey_q;
  logic [ptt_pkg::StatW-1:0] stat_q;

  // lookup of the named key and the lowest free slot
  logic hit, free;
  logic [IdxW-1:0] hit_idx, free_idx;
  always_comb begin
    hit = 1'b0; free = 1'b0; hit_idx = '0; free_idx = '0;
    for (int i = NumTimers - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == req_q.key) begin
        hit = 1'b1; hit_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free = 1'b1; free_idx = IdxW'(i);
      end
    end
  end

  // candidate test for the ordered walk
  logic cand, better;
  assign cand = valid_q[idx_q] && !doomed_q[idx_q] &&
                (!have_prev_q || key_q[idx_q] > prev_q);
  assign better = !have_pick_q || key_q[idx_q] < key_q[pick_q];

  // expiry test of the picked entry
  logic [ptt_pkg::TimeW:0] elapsed;
  logic expire;
  assign elapsed = {1'b0, req_q.now} - {1'b0, stamp_q[pick_q]};
  assign expire = !elapsed[ptt_pkg::TimeW] &&
                  (elapsed[ptt_pkg::TimeW-1:0] >= {16'd0, period_q[pick_q]});

  assign q_ready_o   = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign fired_o     = fired_q;
  assign fired_key_o = fkey_q;
  assign status_o    = stat_q;
  assign last_o      = last_q;

  // table payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) req_q <= q_req_i;
    if (state_q == S_PICK && pend_q && !out_valid_q) begin
      unique case (req_q.op)
        ptt_pkg::OP_SET: if (!hit && free) begin
          key_q[free_idx] <= req_q.key;
          period_q[free_idx] <= req_q.period;
          stamp_q[free_idx] <= req_q.now;
        end
        ptt_pkg::OP_RESTART: if (hit) stamp_q[hit_idx] <= req_q.now;
        ptt_pkg::OP_NOTIFY: if (hit) stamp_q[hit_idx] <= '0;
        default: ;
      endcase
    end
    if (state_q == S_FIRE && expire) stamp_q[pick_q] <= req_q.now;
  end

  // sequencer: one entry a cycle unless a result waits; one walk per visited key, plus one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0; doomed_q <= '0;
      idx_q <= '0; pick_q <= '0; fkey_idx_q <= '0;
      have_pick_q <= 1'b0; have_prev_q <= 1'b0; any_q <= 1'b0; pend_q <= 1'b0;
      prev_q <= '0;
      out_valid_q <= 1'b0; fired_q <= 1'b0; last_q <= 1'b0;
      fkey_q <= '0; stat_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (q_valid_i) begin
          idx_q <= '0; have_pick_q <= 1'b0; have_prev_q <= 1'b0;
          any_q <= 1'b0; pend_q <= 1'b1;
          state_q <= S_PICK;
        end
        S_PICK: if (!out_valid_q) begin
          if (req_q.op != ptt_pkg::OP_SCAN) begin
            // single-result requests
            pend_q <= 1'b0;
            fired_q <= 1'b0; fkey_q <= '0; last_q <= 1'b1;
            stat_q <= ptt_pkg::ST_OK;
            unique case (req_q.op)
              ptt_pkg::OP_SET:
                if (hit) stat_q <= ptt_pkg::ST_KEY;
                else if (!free) stat_q <= ptt_pkg::ST_FULL;
                else begin
                  valid_q[free_idx] <= 1'b1; doomed_q[free_idx] <= 1'b0;
                end
              ptt_pkg::OP_RESTART, ptt_pkg::OP_NOTIFY:
                if (!hit) stat_q <= ptt_pkg::ST_KEY;
              ptt_pkg::OP_KILL:
                if (!hit) stat_q <= ptt_pkg::ST_KEY;
                else doomed_q[hit_idx] <= 1'b1;
              ptt_pkg::OP_KILL_ALL: doomed_q <= doomed_q | valid_q;
              ptt_pkg::OP_CLEAR: begin valid_q <= '0; doomed_q <= '0; end
              default: ;
            endcase
            state_q <= S_OUT;
          end else begin
            if (cand && better) begin
              have_pick_q <= 1'b1; pick_q <= idx_q;
            end
            if (idx_q == IdxW'(NumTimers - 1)) begin
              idx_q <= '0;
              state_q <= (have_pick_q || cand) ? S_FIRE : S_PURGE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        S_FIRE: if (!out_valid_q) begin
          // deliver the previous fired entry now that its successor is known
          if (expire) begin
            if (any_q) begin
              out_valid_q <= 1'b1; fired_q <= 1'b1; last_q <= 1'b0;
              fkey_q <= key_q[fkey_idx_q]; stat_q <= ptt_pkg::ST_OK;
            end
            any_q <= 1'b1; fkey_idx_q <= pick_q;
          end
          have_prev_q <= 1'b1; prev_q <= key_q[pick_q];
          have_pick_q <= 1'b0;
          state_q <= S_PICK;
        end
        S_PURGE: if (!out_valid_q) begin
          valid_q <= valid_q & ~doomed_q;
          doomed_q <= '0;
          fired_q <= any_q; fkey_q <= any_q ? key_q[fkey_idx_q] : '0;
          last_q <= 1'b1; stat_q <= ptt_pkg::ST_OK;
          state_q <= S_OUT;
        end
        S_OUT: if (!out_valid_q) begin
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/periodic_timer_table.sv =====
// top level of the periodic timer table
`timescale 1ns / 1ps
// Periodic timer table with up to NumTimers entries keyed by a 16-bit id.
// Requests enter on the in_valid_i / in_ready_o channel with operation,
// timer_key, period_ms and now_ms; results leave on out_valid_o /
// out_ready_i with fired, fired_key, status and last.
// A two-deep queue decouples intake from the table sequencer, so up to
// two requests are taken while the sequencer is busy.
// Non-scan requests give one result with last set.
// A scan walks the table once per visited live key and once more, each
// visited key followed by its expiry test; it yields one result per fired
// timer in ascending id order, or one result with fired clear if none fire.
// Reset empties the table and the queue; key, period and stamp storage
// is not cleared, only the valid bits.
// When the receiver stalls, the result register holds and the sequencer
// waits; requests still fill the queue until it is full.
module periodic_timer_table #(
  parameter int unsigned NumTimers = ptt_pkg::NumTimersDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ptt_pkg::OpW-1:0]     operation_i,
  input  logic [ptt_pkg::KeyW-1:0]    timer_key_i,
  input  logic [ptt_pkg::PerW-1:0]    period_ms_i,
  input  logic [ptt_pkg::TimeW-1:0]   now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        fired_o,
  output logic [ptt_pkg::KeyW-1:0]    fired_key_o,
  output logic [ptt_pkg::StatW-1:0]   status_o,
  output logic                        last_o
);
  ptt_pkg::req_t req, q_req;
  logic q_valid, q_ready;

  assign req.op = ptt_pkg::op_e'(operation_i);
  assign req.key = timer_key_i;
  assign req.period = period_ms_i;
  assign req.now = now_ms_i;

  ptt_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_i(req),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  ptt_back #(.NumTimers(NumTimers)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid_o, .out_ready_i, .fired_o, .fired_key_o, .status_o, .last_o
  );
endmodule

// ===== dv/periodic_timer_table_test.sv =====
// self-checking testbench for the periodic timer table
`timescale 1ns / 1ps
module periodic_timer_table_test;
  localparam int unsigned Slots = ptt_pkg::NumTimersDefault;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ptt_pkg::OpW-1:0] operation_i = '0;
  logic [ptt_pkg::KeyW-1:0] timer_key_i = '0;
  logic [ptt_pkg::PerW-1:0] period_ms_i = '0;
  logic [ptt_pkg::TimeW-1:0] now_ms_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic fired_o;
  logic [ptt_pkg::KeyW-1:0] fired_key_o;
  logic [ptt_pkg::StatW-1:0] status_o;
  logic last_o;

  typedef struct packed {
    logic fired;
    logic [ptt_pkg::KeyW-1:0] key;
    logic [ptt_pkg::StatW-1:0] status;
    logic last;
  } result_t;

  // directed row: request plus optional typed-in status
  typedef struct {
    ptt_pkg::op_e op;
    logic [ptt_pkg::KeyW-1:0] key;
    logic [ptt_pkg::PerW-1:0] period;
    logic [ptt_pkg::TimeW-1:0] now;
    bit has_status;
    ptt_pkg::status_e status;
  } row_t;

  periodic_timer_table dut (.*);

  always #6 clk_i = ~clk_i;

  // shadow copy of the timer table
  bit tbl_valid [Slots];
  logic [ptt_pkg::KeyW-1:0] tbl_key [Slots];
  logic [ptt_pkg::PerW-1:0] tbl_period [Slots];
  logic [ptt_pkg::TimeW-1:0] tbl_stamp [Slots];
  bit tbl_doomed [Slots];

  result_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  logic [ptt_pkg::TimeW-1:0] clock_ms = '0;
  logic [ptt_pkg::KeyW-1:0] key_pool [8];

  function automatic int find_timer(logic [ptt_pkg::KeyW-1:0] key);
    for (int i = 0; i < Slots; i++)
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void push_single(ptt_pkg::status_e st);
    result_t r;
    r = '{fired: 1'b0, key: '0, status: st, last: 1'b1};
    pending_results.push_back(r);
  endfunction

  // scan in ascending key order, restamp fired timers, drop marked ones
  function automatic void predict_scan(logic [ptt_pkg::TimeW-1:0] now);
    int pick;
    int n;
    bit have_prev;
    logic [ptt_pkg::KeyW-1:0] prev;
    result_t r;
    n = 0;
    have_prev = 0;
    prev = '0;
    for (int v = 0; v < Slots; v++) begin
      pick = -1;
      for (int i = 0; i < Slots; i++) begin
        if (!tbl_valid[i] || tbl_doomed[i]) continue;
        if (have_prev && tbl_key[i] <= prev) continue;
        if (pick < 0 || tbl_key[i] < tbl_key[pick]) pick = i;
      end
      if (pick < 0) break;
      have_prev = 1;
      prev = tbl_key[pick];
      if (now >= tbl_stamp[pick] &&
          (now - tbl_stamp[pick]) >= {16'd0, tbl_period[pick]}) begin
        tbl_stamp[pick] = now;
        r = '{fired: 1'b1, key: tbl_key[pick], status: ptt_pkg::ST_OK, last: 1'b0};
        pending_results.push_back(r);
        n++;
      end
    end
    for (int i = 0; i < Slots; i++)
      if (tbl_doomed[i]) begin
        tbl_valid[i] = 0;
        tbl_doomed[i] = 0;
      end
    if (n == 0) push_single(ptt_pkg::ST_OK);
    else pending_results[$].last = 1'b1;
  endfunction

  // expected results of one accepted request
  function automatic void predict_timer_op(ptt_pkg::op_e op, logic [ptt_pkg::KeyW-1:0] key,
                                           logic [ptt_pkg::PerW-1:0] period,
                                           logic [ptt_pkg::TimeW-1:0] now);
    int slot;
    ptt_pkg::status_e st;
    st = ptt_pkg::ST_OK;
    case (op)
      ptt_pkg::OP_SCAN: begin
        predict_scan(now);
        return;
      end
      ptt_pkg::OP_SET: begin
        if (find_timer(key) >= 0) st = ptt_pkg::ST_KEY;
        else begin
          slot = -1;
          for (int i = 0; i < Slots; i++)
            if (!tbl_valid[i] && slot < 0) slot = i;
          if (slot < 0) st = ptt_pkg::ST_FULL;
          else begin
            tbl_valid[slot] = 1;
            tbl_key[slot] = key;
            tbl_period[slot] = period;
            tbl_stamp[slot] = now;
            tbl_doomed[slot] = 0;
          end
        end
      end
      ptt_pkg::OP_RESTART, ptt_pkg::OP_NOTIFY, ptt_pkg::OP_KILL: begin
        slot = find_timer(key);
        if (slot < 0) st = ptt_pkg::ST_KEY;
        else if (op == ptt_pkg::OP_RESTART) tbl_stamp[slot] = now;
        else if (op == ptt_pkg::OP_NOTIFY) tbl_stamp[slot] = '0;
        else tbl_doomed[slot] = 1;
      end
      ptt_pkg::OP_KILL_ALL: begin
        for (int i = 0; i < Slots; i++)
          if (tbl_valid[i]) tbl_doomed[i] = 1;
      end
      ptt_pkg::OP_CLEAR: begin
        for (int i = 0; i < Slots; i++) begin
          tbl_valid[i] = 0;
          tbl_doomed[i] = 0;
        end
      end
      default: ;
    endcase
    push_single(st);
  endfunction

  // drive one request and hold it until accepted
  task automatic send_request(ptt_pkg::op_e op, logic [ptt_pkg::KeyW-1:0] key,
                              logic [ptt_pkg::PerW-1:0] period,
                              logic [ptt_pkg::TimeW-1:0] now);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    timer_key_i <= key;
    period_ms_i <= period;
    now_ms_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
    predict_timer_op(op, key, period, now);
  endtask

  // receiver with random stall bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(0, 8);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    result_t exp_r;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result fired=%0d key=%0d", fired_o, fired_key_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (fired_o !== exp_r.fired) begin
          $error("fired expected %0d actual %0d", exp_r.fired, fired_o);
          errors++;
        end
        if (fired_key_o !== exp_r.key) begin
          $error("fired_key expected %0d actual %0d", exp_r.key, fired_key_o);
          errors++;
        end
        if (status_o !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, status_o);
          errors++;
        end
        if (last_o !== exp_r.last) begin
          $error("last expected %0d actual %0d", exp_r.last, last_o);
          errors++;
        end
      end
    end
  end

  // timeout guard
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  row_t rows [$];

  initial begin
    ptt_pkg::op_e op;
    int pick;
    logic [ptt_pkg::TimeW-1:0] max_ms;
    max_ms = '1;
    for (int i = 0; i < 8; i++) key_pool[i] = 16'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;

    // directed table: extremes, every operation, special cases
    rows = '{
      '{ptt_pkg::OP_SCAN, 16'd0, 32'd0, 48'd0, 1, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_RESTART, 16'd5, 32'd0, 48'd1, 1, ptt_pkg::ST_KEY},
      '{ptt_pkg::OP_NOTIFY, 16'd5, 32'd0, 48'd1, 1, ptt_pkg::ST_KEY},
      '{ptt_pkg::OP_KILL, 16'd5, 32'd0, 48'd1, 1, ptt_pkg::ST_KEY},
      '{ptt_pkg::OP_SET, 16'hFFFF, 32'hFFFF_FFFF, 48'd0, 1, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_SET, 16'd0, 32'd0, 48'd10, 1, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_SET, 16'd0, 32'd7, 48'd10, 1, ptt_pkg::ST_KEY},
      '{ptt_pkg::OP_SET, 16'h00A5, 32'd100, 48'hFFFF_FFFF_FFFF, 1, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_SCAN, 16'd0, 32'd0, 48'd5, 0, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_SCAN, 16'd0, 32'd0, 48'h1_0000_0000, 0, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_NOTIFY, 16'hFFFF, 32'd0, 48'd0, 1, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_SCAN, 16'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 0, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_RESTART, 16'd0, 32'd0, 48'd3, 1, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_KILL, 16'd0, 32'd0, 48'd3, 1, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_RESTART, 16'd0, 32'd0, 48'd4, 1, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_SET, 16'd0, 32'd1, 48'd4, 1, ptt_pkg::ST_KEY},
      '{ptt_pkg::OP_SCAN, 16'd0, 32'd0, 48'd100, 0, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_NONE, 16'd0, 32'd0, 48'd0, 1, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_KILL_ALL, 16'd0, 32'd0, 48'd0, 1, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_SCAN, 16'd0, 32'd0, 48'd0, 1, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_SET, 16'd9, 32'd0, 48'd50, 1, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_CLEAR, 16'd0, 32'd0, 48'd0, 1, ptt_pkg::ST_OK},
      '{ptt_pkg::OP_SCAN, 16'd0, 32'd0, 48'd60, 1, ptt_pkg::ST_OK}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_request(rows[i].op, rows[i].key, rows[i].period, rows[i].now);
      if (rows[i].has_status && pending_results[$].status != rows[i].status) begin
        $error("status expected %0d actual %0d", rows[i].status,
               pending_results[$].status);
        errors++;
      end
    end

    // fill the table to check the full case
    for (int i = 0; i < 17; i++)
      send_request(ptt_pkg::OP_SET, 16'(i + 100), 32'($urandom_range(0, 40)), clock_ms);
    send_request(ptt_pkg::OP_SCAN, '0, '0, clock_ms + 48'd20);
    send_request(ptt_pkg::OP_CLEAR, '0, '0, '0);

    // random part: advancing time with mostly real keys
    for (int n = 0; n < 130; n++) begin
      if (n > 105) calm = 1'b1;
      clock_ms += 48'($urandom_range(0, 30));
      pick = $urandom_range(0, 99);
      if (pick < 35) op = ptt_pkg::OP_SCAN;
      else if (pick < 60) op = ptt_pkg::OP_SET;
      else if (pick < 70) op = ptt_pkg::OP_RESTART;
      else if (pick < 78) op = ptt_pkg::OP_NOTIFY;
      else if (pick < 88) op = ptt_pkg::OP_KILL;
      else if (pick < 92) op = ptt_pkg::OP_KILL_ALL;
      else if (pick < 95) op = ptt_pkg::OP_CLEAR;
      else op = ptt_pkg::OP_NONE;
      if ($urandom_range(0, 19) == 0)
        send_request(op, 16'($urandom), $urandom, 48'({$urandom, $urandom}) & max_ms);
      else
        send_request(op, $urandom_range(0, 9) == 0 ? 16'($urandom)
                                                   : key_pool[$urandom_range(0, 7)],
                     $urandom_range(0, 9) == 0 ? $urandom : 32'($urandom_range(0, 60)),
                     clock_ms);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
